[src/b64_pkg.sv]
// Shared types, codes and character mapping functions for the base64 codec.
// Used by b64_step, b64_emit and base64_codec; depends on nothing else.
package b64_pkg;

    // Most result words that one input word can cause, and the widths that follow.
    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);

    // Mode codes carried on the input channel.
    localparam logic ModeEncode = 1'b0;
    localparam logic ModeDecode = 1'b1;

    // Encoder group phases: data bytes already taken in the current group.
    localparam logic [1:0] Phase0 = 2'd0;
    localparam logic [1:0] Phase1 = 2'd1;
    localparam logic [1:0] Phase2 = 2'd2;

    // The padding character '='.
    localparam logic [7:0] PadChar = 8'h3D;

    // One accepted input word.
    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
        logic       stream_end;
    } t_item;

    // Codec state kept between words; encoder and decoder parts are separate.
    typedef struct packed {
        logic [7:0]  held;
        logic [1:0]  phase;
        logic [11:0] acc;
        logic [3:0]  pend;
        logic        pad_seen;
    } t_state;

    // All results of one input word, emitted in order from element 0.
    typedef struct packed {
        logic [CountW-1:0]            count;
        logic [MaxResults-1:0][7:0]   bytes;
        logic                         done;
    } t_bundle;

    // Sextet to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        c = {2'b00, s};
        if (s < 6'd26) begin
            return 8'h41 + c;
        end else if (s < 6'd52) begin
            return 8'h61 + c - 8'd26;
        end else if (s < 6'd62) begin
            return 8'h30 + c - 8'd52;
        end else if (s == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // Character to sextet; bit 6 set marks a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            return {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            return 7'd62;
        end else if (c == 8'h2F) begin
            return 7'd63;
        end else begin
            return 7'h40;
        end
    endfunction

endpackage

[src/b64_step.sv]
// Combinational step of the codec: one input word and the current state give
// the result bundle and the next state. Depends on b64_pkg.
module b64_step (
    input  b64_pkg::t_item   i_item,
    input  b64_pkg::t_state  i_state,
    output b64_pkg::t_state  o_state,
    output b64_pkg::t_bundle o_bundle
);
    import b64_pkg::*;

    logic [7:0]  b;
    logic [7:0]  prev;
    logic [6:0]  sx;
    logic [4:0]  p;
    logic [11:0] acc_n;
    logic [2:0]  sh;

    always_comb begin
        b      = i_item.in_byte;
        prev   = i_state.held;
        sx     = sextet_of(b);
        p      = {1'b0, i_state.pend} + 5'd6;
        acc_n  = {i_state.acc[5:0], sx[5:0]};
        sh     = 3'(p - 5'd8);
        o_state  = i_state;
        o_bundle = '0;
        o_bundle.done = i_item.stream_end;

        if (i_item.mode == ModeEncode) begin
            // Encoder: emit each character as soon as its six bits are known.
            case (i_state.phase)
                Phase0: begin
                    o_bundle.bytes[0] = enc_char(b[7:2]);
                    if (i_item.stream_end) begin
                        o_bundle.bytes[1] = enc_char({b[1:0], 4'b0000});
                        o_bundle.bytes[2] = PadChar;
                        o_bundle.bytes[3] = PadChar;
                        o_bundle.count    = CountW'(4);
                    end else begin
                        o_bundle.count    = CountW'(1);
                    end
                    o_state.phase = Phase1;
                end
                Phase1: begin
                    o_bundle.bytes[0] = enc_char({prev[1:0], b[7:4]});
                    if (i_item.stream_end) begin
                        o_bundle.bytes[1] = enc_char({b[3:0], 2'b00});
                        o_bundle.bytes[2] = PadChar;
                        o_bundle.count    = CountW'(3);
                    end else begin
                        o_bundle.count    = CountW'(1);
                    end
                    o_state.phase = Phase2;
                end
                default: begin
                    o_bundle.bytes[0] = enc_char({prev[3:0], b[7:6]});
                    o_bundle.bytes[1] = enc_char(b[5:0]);
                    o_bundle.count    = CountW'(2);
                    o_state.phase     = Phase0;
                end
            endcase
            o_state.held = b;
        end else if (!i_state.pad_seen) begin
            // Decoder: gather sextets and emit a byte once eight bits are ready.
            if (b == PadChar) begin
                o_state.pad_seen = 1'b1;
            end else if (!sx[6]) begin
                o_state.acc = acc_n;
                if (p >= 5'd8 && p <= 5'd12) begin
                    o_bundle.bytes[0] = 8'(acc_n >> sh);
                    o_bundle.count    = CountW'(1);
                    o_state.pend      = 4'(p - 5'd8);
                end else if (p > 5'd12) begin
                    o_state.pend = 4'd12;
                end else begin
                    o_state.pend = 4'(p);
                end
            end
        end

        // The stream-end word clears all state once it has been processed.
        if (i_item.stream_end) begin
            o_state = '0;
        end
    end

endmodule

[src/b64_emit.sv]
// Result register of the codec: holds one bundle and sends its words one per
// cycle on the output channel while i_stall is low. Depends on b64_pkg.
module b64_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  b64_pkg::t_bundle i_bundle,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_stream_done
);
    import b64_pkg::*;

    logic            r_valid;
    logic [IdxW-1:0] r_idx;
    t_bundle         r_bnd;
    logic            last;

    // The word on show is the last one of its bundle.
    assign last = (CountW'(r_idx) + CountW'(1)) == r_bnd.count;

    // The register can take a new bundle when empty or when its last word leaves.
    assign o_free = !r_valid || (!i_stall && last);

    assign o_valid       = r_valid;
    assign o_out_byte    = r_bnd.bytes[r_idx];
    assign o_run_last    = last;
    assign o_stream_done = r_bnd.done;

    // Control: occupancy and the index of the word on show.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && !i_stall) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IdxW'(1);
            end
        end
    end

    // Payload: the bundle itself.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bnd <= i_bundle;
        end
    end

endmodule

[src/base64_codec.sv]
// Streaming base64 encoder and decoder, top level.
// Depends on b64_pkg, b64_step and b64_emit.
//
// Input channel: i_valid, o_stall and the word i_mode, i_in_byte, i_stream_end.
// A word is taken at a rising edge with i_valid high and o_stall low. Mode 0
// encodes a data byte, mode 1 decodes one base64 character.
// Output channel: o_valid, i_stall and the word o_out_byte, o_run_last,
// o_stream_done. A word leaves at an edge with o_valid high and i_stall low.
// o_run_last marks the last result of an input word; o_stream_done marks every
// result of a stream-end word.
// An input word is held in the input register, its results are computed
// combinationally into the result register, and the first of them goes on the
// output from there.
// The result register sends one word per cycle while the output is not stalled.
// An input word has one or two results while encoding mid-stream, up to four at
// an encoder stream end, and at most one while decoding. Words with no result pass
// without using it. A new input word is taken while earlier results still drain.
// Reset empties both registers and clears all codec state. When the receiver stalls,
// the word on show holds, and the input side stalls once the input register is
// full and its results cannot move on.
module base64_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_done
);
    import b64_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    t_state  r_state;
    t_state  n_state;
    t_bundle bundle;
    logic    emit_free;
    logic    advance;
    logic    in_accept;
    logic    load;

    // Work on the registered word.
    b64_step u_step (
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_bundle (bundle)
    );

    // The registered word moves on when it has no result or the result
    // register can take its bundle.
    assign advance   = r_in_valid && ((bundle.count == '0) || emit_free);
    assign load      = advance && (bundle.count != '0);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    b64_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_bundle      (bundle),
        .i_stall       (i_stall),
        .o_free        (emit_free),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

    // Input register occupancy and codec state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.mode       <= i_mode;
            r_item.in_byte    <= i_in_byte;
            r_item.stream_end <= i_stream_end;
        end
    end

endmodule
